### src/mfu_pkg.sv
`default_nettype none

package mfu_pkg;

   localparam int NUMBER_WIDTH       = 14;
   localparam int VALUE_WIDTH        = 2;
   localparam int DIVISOR_WIDTH      = 8;
   localparam int SQUARE_WIDTH       = 2 * DIVISOR_WIDTH;
   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = 4;
   localparam int DIV_WORK_WIDTH     = DIV_BITS_PER_CYCLE * DIV_CYCLES;
   localparam int DIV_COUNT_WIDTH    = $clog2(DIV_CYCLES);
   localparam int REQ_TDATA_WIDTH    = ((NUMBER_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH    = ((VALUE_WIDTH + 7) / 8) * 8;

   localparam logic [DIVISOR_WIDTH-1:0] FIRST_DIVISOR  = DIVISOR_WIDTH'(2);
   localparam logic [DIVISOR_WIDTH-1:0] SECOND_DIVISOR = DIVISOR_WIDTH'(3);
   localparam logic [DIVISOR_WIDTH-1:0] DIVISOR_STRIDE = DIVISOR_WIDTH'(2);

   localparam logic signed [VALUE_WIDTH-1:0] MU_PLUS_ONE  = 2'sb01;
   localparam logic signed [VALUE_WIDTH-1:0] MU_ZERO      = 2'sb00;
   localparam logic signed [VALUE_WIDTH-1:0] MU_MINUS_ONE = 2'sb11;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_DIV_FIRST,
      SEQ_DIV_SECOND,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic                     start;
      logic [NUMBER_WIDTH-1:0]  dividend;
      logic [DIVISOR_WIDTH-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [NUMBER_WIDTH-1:0] quotient;
      logic                    rem_zero;
   } div_rsp_type;

   typedef struct packed {
      logic                          valid;
      logic signed [VALUE_WIDTH-1:0] value;
   } seq_status_type;

endpackage

`default_nettype wire

### src/mfu_divider.sv
`default_nettype none

module mfu_divider
   import mfu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_rsp_type      rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WORK_WIDTH-1:0]  work_ff, work_in;
   logic [DIVISOR_WIDTH-1:0]   divisor_ff, divisor_in;

   always_comb begin
      logic [DIVISOR_WIDTH-1:0]  rem_w;
      logic [DIV_WORK_WIDTH-1:0] work_w;
      rem_w      = rem_ff;
      work_w     = work_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_w      = '0;
         work_w     = {{(DIV_WORK_WIDTH-NUMBER_WIDTH){1'b0}}, cmd.dividend};
         divisor_in = cmd.divisor;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
            rem_w  = {rem_w[DIVISOR_WIDTH-2:0], work_w[DIV_WORK_WIDTH-1]};
            work_w = {work_w[DIV_WORK_WIDTH-2:0], 1'b0};
            if (rem_w >= divisor_ff) begin
               rem_w     = rem_w - divisor_ff;
               work_w[0] = 1'b1;
            end
         end
         count_in = count_ff + DIV_COUNT_WIDTH'(1);
         if (count_ff == DIV_COUNT_WIDTH'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      rem_in  = rem_w;
      work_in = work_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = work_ff[NUMBER_WIDTH-1:0];
   assign rsp.rem_zero = (rem_ff == '0);

endmodule

`default_nettype wire

### src/mfu_sequencer.sv
`default_nettype none

module mfu_sequencer
   import mfu_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    number_valid,
   input  wire logic [NUMBER_WIDTH-1:0] number_in,
   output logic                         number_ready,
   output seq_status_type               status,
   input  wire logic                    result_taken,
   output div_cmd_type                  div_cmd,
   input  wire div_rsp_type             div_rsp
);

   seq_state_type                 state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]       rest_ff, rest_in;
   logic [DIVISOR_WIDTH-1:0]      divisor_ff, divisor_in;
   logic                          parity_ff, parity_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [SQUARE_WIDTH-1:0]       square;
   logic                          in_range;
   logic [DIVISOR_WIDTH-1:0]      next_divisor;

   assign square       = SQUARE_WIDTH'(divisor_ff) * SQUARE_WIDTH'(divisor_ff);
   assign in_range     = square <= SQUARE_WIDTH'(rest_ff);
   assign next_divisor = (divisor_ff == FIRST_DIVISOR) ? SECOND_DIVISOR
                                                       : divisor_ff + DIVISOR_STRIDE;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (number_valid) begin
               state_in = (number_in == '0) ? SEQ_DONE : SEQ_CHECK;
            end
         end
         SEQ_CHECK: begin
            state_in = in_range ? SEQ_DIV_FIRST : SEQ_DONE;
         end
         SEQ_DIV_FIRST: begin
            if (div_rsp.done) begin
               state_in = div_rsp.rem_zero ? SEQ_DIV_SECOND : SEQ_CHECK;
            end
         end
         SEQ_DIV_SECOND: begin
            if (div_rsp.done) begin
               state_in = div_rsp.rem_zero ? SEQ_DONE : SEQ_CHECK;
            end
         end
         SEQ_DONE: begin
            if (result_taken) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      rest_in          = rest_ff;
      divisor_in       = divisor_ff;
      parity_in        = parity_ff;
      value_in         = value_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = rest_ff;
      div_cmd.divisor  = divisor_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (number_valid) begin
               rest_in    = number_in;
               divisor_in = FIRST_DIVISOR;
               parity_in  = 1'b0;
               value_in   = MU_ZERO;
            end
         end
         SEQ_CHECK: begin
            if (in_range) begin
               div_cmd.start = 1'b1;
            end else begin
               value_in = (parity_ff ^ (rest_ff > NUMBER_WIDTH'(1))) ? MU_MINUS_ONE
                                                                    : MU_PLUS_ONE;
            end
         end
         SEQ_DIV_FIRST: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  rest_in          = div_rsp.quotient;
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = div_rsp.quotient;
               end else begin
                  divisor_in = next_divisor;
               end
            end
         end
         SEQ_DIV_SECOND: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  value_in = MU_ZERO;
               end else begin
                  parity_in  = ~parity_ff;
                  divisor_in = next_divisor;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rest_ff    <= rest_in;
      divisor_ff <= divisor_in;
      parity_ff  <= parity_in;
      value_ff   <= value_in;
   end

   assign number_ready = (state_ff == SEQ_IDLE);
   assign status.valid = (state_ff == SEQ_DONE);
   assign status.value = value_ff;

endmodule

`default_nettype wire

### src/mobius_function_unit.sv
// Mobius function unit: returns mu(n) for a 14-bit unsigned n.
// Input channel req_*: one transaction carries n in req_tdata[13:0].
// Result channel rsp_*: one transaction per input, mu(n) in rsp_tdata[1:0] as
// two's complement (01 = +1, 00 = 0, 11 = -1). n = 0 answers 0, n = 1 answers +1.
// n is factored by trial division with candidates 2, 3, 5, 7, ... while the
// square of the candidate does not exceed the unfactored rest. Every candidate
// takes a compare step and, while in range, one pass through the shared
// divider, which resolves 4 quotient bits per cycle; a candidate that divides
// costs a second division. The block handles one transaction at a time;
// req_tready is low from acceptance until the result is handed to the output
// register. The output register holds the result while rsp_tready is low, and
// a new input is accepted while that result waits. A stall keeps the sequencer
// in its done state once a second result is ready.
// Reset (synchronous, active high) returns the sequencer to idle and empties
// the output register.
`default_nettype none

module mobius_function_unit
   import mfu_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,  // [13:0] number_in
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata   // [1:0] mobius_value
);

   div_cmd_type                   div_cmd;
   div_rsp_type                   div_rsp;
   seq_status_type                status;
   logic                          load;
   logic                          out_valid_ff, out_valid_in;
   logic signed [VALUE_WIDTH-1:0] out_value_ff, out_value_in;

   mfu_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .number_valid (req_tvalid),
      .number_in    (req_tdata[NUMBER_WIDTH-1:0]),
      .number_ready (req_tready),
      .status       (status),
      .result_taken (load),
      .div_cmd      (div_cmd),
      .div_rsp      (div_rsp)
   );

   mfu_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign load = status.valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_value_in = status.value;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_value_ff <= out_value_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_WIDTH-VALUE_WIDTH){1'b0}}, out_value_ff};

endmodule

`default_nettype wire

### src/mfu_checker.sv
`default_nettype none

module mfu_checker
   import mfu_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic req_accept;

   assign req_accept = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input taken while a transaction is in progress");

   a_value_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[VALUE_WIDTH-1:0] != 2'b10))
      else $error("result outside -1..1");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_WIDTH-1:VALUE_WIDTH] == '0))
      else $error("result padding not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

endmodule

bind mobius_function_unit mfu_checker u_mfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
